// ===== hw/rtl/vertex_transform_4x4_core_assert.svh =====
// Assertion macros for the vertex transform core.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef VERTEX_TRANSFORM_4X4_CORE_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define VT4_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vt4 assertion failed");
// Next-cycle implication.
`define VT4_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vt4 assertion failed");
`else
`define VT4_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VT4_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/vt4_pkg.sv =====
// Shared types, widths and helpers for the vertex transform core.
// No dependencies; imported by every module of the block.
package vt4_pkg;

  localparam int ELEM_W = 32;                 // Q16.16 element width
  localparam int FRAC_W = 16;                 // fraction bits
  localparam int DIM    = 4;                  // matrix order
  localparam int IDX_W  = $clog2(DIM);        // row or column index
  localparam int PROD_W = 2 * ELEM_W;         // full product
  localparam int SUM_W  = PROD_W + IDX_W;     // exact sum of DIM products
  localparam int SHR_W  = SUM_W - FRAC_W;     // sum after fraction drop

  // Item kind carried in tuser
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_e;

  // Element write broadcast to the cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] val;
  } mat_wr_t;

  // Partial row sum travelling down the cell chain
  typedef struct packed {
    logic                    vld;
    logic [IDX_W-1:0]        row;
    logic signed [SUM_W-1:0] sum;
  } row_tok_t;

  // Identity element at (row, col): 1.0 on the diagonal, 0 elsewhere
  function automatic logic [ELEM_W-1:0] ident_elem(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    logic [ELEM_W-1:0] one;
    one = ELEM_W'(1) << FRAC_W;
    return (row == col) ? one : '0;
  endfunction

endpackage

// ===== hw/rtl/vt4_cell.sv =====
// One column cell of the transform chain: holds one matrix column,
// multiplies it by its vertex component and adds to the passing row sum.
// Depends on vt4_pkg.
module vt4_cell import vt4_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IDX_W-1:0]         col_i,   // column this cell owns
  input  mat_wr_t                  wr_i,    // element write
  input  logic signed [ELEM_W-1:0] vec_i,   // vertex component of this column
  input  row_tok_t                 tok_i,   // row sum from the left neighbor
  output row_tok_t                 tok_o    // row sum to the right neighbor
);

  // Column held XORed with the identity column, so reset clears it to zero (identity)
  logic [ELEM_W-1:0]        col_q [DIM];
  logic signed [ELEM_W-1:0] elem;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pass_vld_q;
  logic [IDX_W-1:0]         pass_row_q;
  logic signed [SUM_W-1:0]  pass_sum_q;
  logic                     tok_vld_q;
  logic [IDX_W-1:0]         tok_row_q;
  logic signed [SUM_W-1:0]  tok_sum_q;

  // Store element writes aimed at this column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) col_q[r] <= '0;
    end else if (wr_i.en && (wr_i.col == col_i)) begin
      col_q[wr_i.row] <= wr_i.val ^ ident_elem(wr_i.row, col_i);
    end
  end

  assign elem = signed'(col_q[tok_i.row] ^ ident_elem(tok_i.row, col_i));

  // Multiply stage: register product and hold the incoming sum beside it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_vld_q <= 1'b0;
    end else begin
      pass_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= elem * vec_i;
    pass_row_q <= tok_i.row;
    pass_sum_q <= tok_i.sum;
  end

  // Add stage: fold the product into the row sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= pass_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_row_q <= pass_row_q;
    tok_sum_q <= pass_sum_q + SUM_W'(prod_q);
  end

  assign tok_o.vld = tok_vld_q;
  assign tok_o.row = tok_row_q;
  assign tok_o.sum = tok_sum_q;

endmodule

// ===== hw/rtl/vt4_sat.sv =====
// Fraction drop and saturation of one exact row sum to Q16.16.
// Depends on vt4_pkg.
module vt4_sat import vt4_pkg::*; (
  input  logic signed [SUM_W-1:0] sum_i,
  output logic [ELEM_W-1:0]       val_o,
  output logic                    ovf_o
);

  logic signed [SHR_W-1:0]     shr;
  logic [SHR_W-ELEM_W:0]       top;
  logic [ELEM_W-1:0]           max_v;
  logic [ELEM_W-1:0]           min_v;

  // Drop fraction bits, rounding toward minus infinity
  assign shr   = SHR_W'(sum_i >>> FRAC_W);
  assign top   = shr[SHR_W-1:ELEM_W-1];
  assign max_v = {1'b0, {(ELEM_W-1){1'b1}}};
  assign min_v = {1'b1, {(ELEM_W-1){1'b0}}};

  // Clamp when the upper bits are not a pure sign extension
  assign ovf_o = !((&top) || !(|top));
  assign val_o = !ovf_o ? shr[ELEM_W-1:0] : (sum_i[SUM_W-1] ? min_v : max_v);

endmodule

// ===== hw/rtl/vertex_transform_4x4_core.sv =====
// Top level of the 4x4 vertex transform: item decode, row sequencer,
// cell chain, result collector and output register.
// Depends on vt4_pkg, vt4_cell, vt4_sat and the assertion header.
//
// Multiplies a stored 4x4 signed Q16.16 matrix (identity after reset) by
// each vertex (x, y, z, w) and returns the four row dot products,
// truncated toward minus infinity and saturated to Q16.16, with tuser high
// when any component was clamped. A load transaction (tuser 0) writes one
// element at index row*4+col and produces no output. A vertex transaction
// (tuser 1) issues its four rows one per cycle into a chain of four column
// cells, each with a registered multiply and a registered add; the block
// takes its next transaction once the result has passed the four-row issue,
// the 8-stage chain and the collector and moved into the output register,
// and later if the previous result still waits unaccepted in the output
// register. A finished result waits in the output register while the next
// transaction is taken.
`include "vertex_transform_4x4_core_assert.svh"
module vertex_transform_4x4_core import vt4_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] elem_index, [35:4] elem_value, [67:36] in_x, [99:68] in_y,
  // [131:100] in_z, [163:132] in_w, [167:164] zero
  input  logic [167:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,  // [0] kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  output logic [127:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser   // [0] overflow
);

  logic                     in_acc;
  logic                     vtx_acc;
  kind_e                    kind;
  mat_wr_t                  mat_wr;
  logic                     busy_q, busy_d;
  logic                     issue_q, issue_d;
  logic [IDX_W-1:0]         issue_row_q, issue_row_d;
  logic signed [ELEM_W-1:0] vec_q [DIM];
  row_tok_t                 tok [DIM+1];
  logic [ELEM_W-1:0]        sat_val;
  logic                     sat_ovf;
  logic [ELEM_W-1:0]        res_q [DIM];
  logic                     ov_q;
  logic                     done_q, done_d;
  logic                     move;
  logic                     m_valid_q, m_valid_d;
  logic [DIM*ELEM_W-1:0]    m_data_q;
  logic                     m_ovf_q;

  // Decode the input transaction
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_e'(s_axis_tuser[0]);
  assign vtx_acc       = in_acc && (kind == KIND_VERTEX);

  assign mat_wr.en  = in_acc && (kind == KIND_LOAD);
  assign mat_wr.row = s_axis_tdata[3:2];
  assign mat_wr.col = s_axis_tdata[1:0];
  assign mat_wr.val = s_axis_tdata[35:4];

  // Hold the vertex for the whole pass
  always_ff @(posedge clk_i) begin
    if (vtx_acc) begin
      for (int c = 0; c < DIM; c++) begin
        vec_q[c] <= signed'(s_axis_tdata[36 + c*ELEM_W +: ELEM_W]);
      end
    end
  end

  // Sequence rows into the chain and track the busy window
  assign move = done_q && (!m_valid_q || m_axis_tready);

  always_comb begin
    busy_d      = busy_q;
    issue_d     = issue_q;
    issue_row_d = issue_row_q;
    if (vtx_acc) begin
      busy_d      = 1'b1;
      issue_d     = 1'b1;
      issue_row_d = '0;
    end else if (issue_q) begin
      issue_row_d = issue_row_q + IDX_W'(1);
      if (issue_row_q == IDX_W'(DIM-1)) issue_d = 1'b0;
    end
    if (move) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issue_q     <= 1'b0;
      issue_row_q <= '0;
    end else begin
      busy_q      <= busy_d;
      issue_q     <= issue_d;
      issue_row_q <= issue_row_d;
    end
  end

  // Feed the chain head with an empty row sum
  assign tok[0].vld = issue_q;
  assign tok[0].row = issue_row_q;
  assign tok[0].sum = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    vt4_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .col_i  (IDX_W'(k)),
      .wr_i   (mat_wr),
      .vec_i  (vec_q[k]),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  vt4_sat u_sat (
    .sum_i (tok[DIM].sum),
    .val_o (sat_val),
    .ovf_o (sat_ovf)
  );

  // Collect rows leaving the chain
  always_ff @(posedge clk_i) begin
    if (tok[DIM].vld) begin
      res_q[tok[DIM].row] <= sat_val;
      ov_q <= (tok[DIM].row == '0) ? sat_ovf : (ov_q || sat_ovf);
    end
  end

  always_comb begin
    done_d = done_q;
    if (tok[DIM].vld && (tok[DIM].row == IDX_W'(DIM-1))) done_d = 1'b1;
    else if (move) done_d = 1'b0;
  end

  // Advance the result into the output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (move) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      m_data_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
      m_ovf_q  <= ov_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_ovf_q;

  // A vertex starts issuing at row zero
  `VT4_ASSERT_NXT(a_issue_start, clk_i, rst_ni, vtx_acc, issue_q && (issue_row_q == '0))
  // No row leaves the chain outside a vertex pass
  `VT4_ASSERT_IMP(a_chain_busy, clk_i, rst_ni, tok[DIM].vld, busy_q)
  // A collected result never overlaps row issue
  `VT4_ASSERT_IMP(a_done_quiet, clk_i, rst_ni, done_q, !issue_q && !tok[DIM].vld)

endmodule

// ===== bench/tb_vertex_transform_4x4_core.sv =====
// Self-checking testbench for vertex_transform_4x4_core: directed table with fixed results, then random
// matrix loads and vertex streams checked against an in-bench fixed-point predictor.
// Depends on vt4_pkg and the core RTL only.
module tb_vertex_transform_4x4_core import vt4_pkg::*;;

  localparam int DATA_W         = 168;
  localparam int ITEM_TARGET    = 1550;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int REPORT_MAX     = 10;

  typedef logic [DIM-1:0][ELEM_W-1:0] vec4_t;  // [0] x ... [3] w

  typedef struct packed {
    logic  ovf;
    vec4_t comp;
  } xform_res_t;

  typedef struct {
    kind_e             kind;
    logic [3:0]        idx;
    logic [ELEM_W-1:0] val;
    vec4_t             vtx;
    bit                typed;
    xform_res_t        want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [127:0]      m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  // Predictor state and expected results
  logic [ELEM_W-1:0] matrix_q [DIM*DIM];
  xform_res_t        pending_results [$];
  stim_row_t         stim_rows [$];

  int error_count = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  vertex_transform_4x4_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic vec4_t mk_vec(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [31:0] w);
    return {w, z, y, x};
  endfunction

  function automatic xform_res_t mk_res(input vec4_t comp, input logic ovf);
    xform_res_t res;
    res.comp = comp;
    res.ovf  = ovf;
    return res;
  endfunction

  // Element value: mostly small or moderate, sometimes full range or a corner value
  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] corners [7];
    corners = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ELEM_W'(signed'(20'($urandom)));
      4:          return $urandom;
      5:          return corners[$urandom_range(0, 6)];
      default:    return ELEM_W'(signed'(24'($urandom)));
    endcase
  endfunction

  function automatic vec4_t rand_vec();
    return mk_vec(rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endfunction

  // Four row dot products, exact sum, floor shift, clamp to the element range
  function automatic xform_res_t transform_vertex(input vec4_t vtx);
    xform_res_t              res;
    logic signed [SUM_W-1:0] acc;
    logic signed [SHR_W-1:0] shr;
    res = '0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++)
        acc = acc + $signed(matrix_q[r*DIM+c]) * $signed(vtx[c]);
      shr = SHR_W'(acc >>> FRAC_W);
      if (shr[SHR_W-1:ELEM_W-1] == '0 || shr[SHR_W-1:ELEM_W-1] == '1) begin
        res.comp[r] = shr[ELEM_W-1:0];
      end else begin
        res.ovf     = 1'b1;
        res.comp[r] = shr[SHR_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end
    end
    return res;
  endfunction

  function automatic void add_load(input logic [3:0] idx, input logic [ELEM_W-1:0] val);
    stim_row_t row;
    row = '{KIND_LOAD, idx, val, rand_vec(), 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_vertex(input vec4_t vtx, input bit typed, input xform_res_t want);
    stim_row_t row;
    row = '{KIND_VERTEX, 4'($urandom), $urandom, vtx, typed, want};
    stim_rows.push_back(row);
  endfunction

  // Drive one transaction in bursts with random gaps, then predict on acceptance
  task automatic send_item(input kind_e kind, input logic [3:0] idx,
                           input logic [ELEM_W-1:0] val, input vec4_t vtx,
                           input bit typed, input xform_res_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, vtx, val, idx};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == KIND_LOAD)
      matrix_q[idx] = val;
    else
      pending_results.push_back(typed ? want : transform_vertex(vtx));
    items_sent++;
  endtask

  // Hold the input side until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: free-running, random, mostly stalled or fully stalled stretches
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 40) : $urandom_range(5, 80);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1);
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk_i) begin
    xform_res_t want;
    xform_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mk_res(m_axis_tdata, m_axis_tuser[0]);
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result: x=%h y=%h z=%h w=%h ovf=%b",
                   got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.ovf);
      end else begin
        want = pending_results.pop_front();
        if (got.comp[0] !== want.comp[0] || got.comp[1] !== want.comp[1] ||
            got.comp[2] !== want.comp[2] || got.comp[3] !== want.comp[3] ||
            got.ovf !== want.ovf) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("mismatch: expected x=%h y=%h z=%h w=%h ovf=%b, got x=%h y=%h z=%h w=%h ovf=%b",
                     want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.ovf,
                     got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.ovf);
        end
      end
    end
  end

  // Count cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int pick;
    int n_load;
    int n_vtx;
    for (int i = 0; i < DIM*DIM; i++)
      matrix_q[i] = (i % (DIM+1) == 0) ? (ELEM_W'(1) << FRAC_W) : '0;

    // Identity after reset passes vertices through unchanged
    add_vertex(mk_vec(32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
               mk_res(mk_vec(32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0));
    add_vertex('0, 1'b1, '0);
    add_vertex(mk_vec(32'h0001_8000, 32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF), 1'b1,
               mk_res(mk_vec(32'h0001_8000, 32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF), 1'b0));
    // Largest element: clamp high and low
    add_load(4'd0, 32'h7FFF_FFFF);
    add_vertex(mk_vec(32'h7FFF_FFFF, 0, 0, 0), 1'b1, mk_res(mk_vec(32'h7FFF_FFFF, 0, 0, 0), 1'b1));
    add_vertex(mk_vec(32'h8000_0000, 0, 0, 0), 1'b1, mk_res(mk_vec(32'h8000_0000, 0, 0, 0), 1'b1));
    // Smallest element: min times min clamps high, min times one ulp stays in range
    add_load(4'd5, 32'h8000_0000);
    add_vertex(mk_vec(0, 32'h8000_0000, 0, 0), 1'b1, mk_res(mk_vec(0, 32'h7FFF_FFFF, 0, 0), 1'b1));
    add_vertex(mk_vec(0, 32'h0000_0001, 0, 0), 1'b1, mk_res(mk_vec(0, 32'hFFFF_8000, 0, 0), 1'b0));
    // Minus one ulp on the diagonal: truncation goes toward minus infinity
    add_load(4'd15, 32'hFFFF_FFFF);
    add_vertex(mk_vec(0, 0, 0, 32'h0000_0001), 1'b1, mk_res(mk_vec(0, 0, 0, 32'hFFFF_FFFF), 1'b0));
    add_vertex(mk_vec(0, 0, 0, 32'h0001_0000), 1'b1, mk_res(mk_vec(0, 0, 0, 32'hFFFF_FFFF), 1'b0));
    // Sum of two in-range products overflows
    add_load(4'd3, 32'h0002_0000);
    add_vertex(mk_vec(32'h0001_0000, 0, 0, 32'h0001_0000), 1'b1,
               mk_res(mk_vec(32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF), 1'b1));
    // Mixed matrix, checked by the predictor
    add_load(4'd12, 32'h1234_5678);
    add_load(4'd10, 32'hFFFF_0000);
    add_load(4'd6, 32'h0000_8000);
    add_vertex(rand_vec(), 1'b0, '0);
    add_vertex(mk_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0);
    add_vertex(mk_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0);
    add_load(4'd0, 32'h0001_0000);
    add_vertex(rand_vec(), 1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      send_item(stim_rows[i].kind, stim_rows[i].idx, stim_rows[i].val, stim_rows[i].vtx,
                stim_rows[i].typed, stim_rows[i].want);
    drain_results();

    // Random part: mostly matrix updates followed by vertex streams
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        n_load = (pick < 4) ? DIM*DIM : $urandom_range(0, 6);
        n_vtx  = (pick < 4) ? DIM : $urandom_range(1, 10);
        for (int i = 0; i < n_load; i++)
          send_item(KIND_LOAD, (n_load == DIM*DIM) ? 4'(i) : 4'($urandom), rand_elem(),
                    rand_vec(), 1'b0, '0);
        for (int i = 0; i < n_vtx; i++)
          send_item(KIND_VERTEX, 4'($urandom), $urandom, rand_vec(), 1'b0, '0);
      end else if (pick < 19) begin
        send_item(kind_e'($urandom_range(0, 1)), 4'($urandom), rand_elem(), rand_vec(),
                  1'b0, '0);
      end else begin
        drain_results();
      end
    end

    // Wait for the tail, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    error_count += pending_results.size();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
